### rtl/core/cse_pkg.sv
// Shared types and constants of the cosine similarity engine.
// No dependencies; every other file of the block depends on this package.
package cse_pkg;

	localparam int CSE_MAX_LEN   = 1024;
	localparam int CSE_ELEM_BITS = 16;

	localparam int CSE_DOT_W     = 42;
	localparam int CSE_SQ_W      = 41;
	localparam int CSE_COS_W     = 16;
	localparam int CSE_ROOT_W    = 64;
	localparam int CSE_NORM_W    = 32;
	localparam int CSE_NUM_SHIFT = 22;
	localparam int CSE_FRAC_BITS = 16;
	localparam int CSE_ROOT_STEPS = CSE_ROOT_W / 2;
	localparam int CSE_DIV_STEPS  = CSE_FRAC_BITS;
	localparam int CSE_CNT_W     = $clog2(CSE_ROOT_STEPS);

	localparam logic [CSE_COS_W-1:0] CSE_COS_MAX = 16'd32767;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ZERO_NORM = 2'd1,
		ST_TOO_LONG  = 2'd2
	} cse_status_t;

	// Sums of a finished vector pair, valid for one cycle.
	typedef struct packed {
		logic                 valid;
		logic                 ovf;
		logic [CSE_DOT_W-1:0] dot;
		logic [CSE_SQ_W-1:0]  sqa;
		logic [CSE_SQ_W-1:0]  sqb;
	} cse_fin_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic root;
		logic mult;
		logic cmp;
		logic div;
		logic emit;
	} cse_cmd_t;

endpackage

### rtl/core/cse_in_if.sv
// Input channel of the cosine similarity engine: element pairs.
// Depends on cse_pkg.
interface cse_in_if #(
	parameter int ELEM_BITS = cse_pkg::CSE_ELEM_BITS
);
	logic                        valid;
	logic                        ready;
	logic signed [ELEM_BITS-1:0] elem_a;
	logic signed [ELEM_BITS-1:0] elem_b;
	logic                        last_element;

	modport source (output valid, output elem_a, output elem_b, output last_element,
		input ready);
	modport sink (input valid, input elem_a, input elem_b, input last_element,
		output ready);
endinterface

### rtl/core/cse_out_if.sv
// Output channel of the cosine similarity engine: one result per vector pair.
// Depends on cse_pkg.
interface cse_out_if;
	import cse_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [CSE_COS_W-1:0] cosine;
	logic signed [CSE_DOT_W-1:0] dot_sum;
	logic [1:0]                  status;

	modport source (output valid, output cosine, output dot_sum, output status,
		input ready);
	modport sink (input valid, input cosine, input dot_sum, input status,
		output ready);
endinterface

### rtl/core/cse_accum.sv
// Element stage: per-pair products, running sums, length count and overflow.
// Depends on cse_pkg.
module cse_accum #(
	parameter int MAX_LEN   = cse_pkg::CSE_MAX_LEN,
	parameter int ELEM_BITS = cse_pkg::CSE_ELEM_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic signed [ELEM_BITS-1:0] elem_a,
	input  logic signed [ELEM_BITS-1:0] elem_b,
	input  logic                        last_element,
	output cse_pkg::cse_fin_t           fin
);
	import cse_pkg::*;

	localparam int PW = 2 * ELEM_BITS;
	localparam int CW = $clog2(MAX_LEN + 1);
	localparam logic [CW-1:0] LEN_LIMIT = CW'(MAX_LEN);

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic          drop;

	logic                 valid_s1, last_s1, keep_s1, ovf_s1;
	logic signed [PW-1:0] pab_s1, paa_s1, pbb_s1;

	logic [CSE_DOT_W-1:0] dot_q;
	logic [CSE_SQ_W-1:0]  sqa_q, sqb_q;
	logic [CSE_DOT_W-1:0] dot_add;
	logic [CSE_SQ_W-1:0]  sqa_add, sqb_add;
	logic signed [63:0]   pab_x, paa_x, pbb_x;

	assign drop = (count_q >= LEN_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovf_q    <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (last_element) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end else if (drop) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= last_element;
			keep_s1 <= !drop;
			ovf_s1  <= ovf_q | drop;
			pab_s1  <= elem_a * elem_b;
			paa_s1  <= elem_a * elem_a;
			pbb_s1  <= elem_b * elem_b;
		end
	end

	// Products wrap into the accumulator widths like the sums do.
	assign pab_x = 64'(pab_s1);
	assign paa_x = 64'(paa_s1);
	assign pbb_x = 64'(pbb_s1);

	assign dot_add = dot_q + (keep_s1 ? pab_x[CSE_DOT_W-1:0] : '0);
	assign sqa_add = sqa_q + (keep_s1 ? paa_x[CSE_SQ_W-1:0] : '0);
	assign sqb_add = sqb_q + (keep_s1 ? pbb_x[CSE_SQ_W-1:0] : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			sqa_q <= '0;
			sqb_q <= '0;
		end else if (valid_s1) begin
			if (last_s1) begin
				dot_q <= '0;
				sqa_q <= '0;
				sqb_q <= '0;
			end else begin
				dot_q <= dot_add;
				sqa_q <= sqa_add;
				sqb_q <= sqb_add;
			end
		end
	end

	assign fin.valid = valid_s1 && last_s1;
	assign fin.ovf   = ovf_s1;
	assign fin.dot   = dot_add;
	assign fin.sqa   = sqa_add;
	assign fin.sqb   = sqb_add;

endmodule

### rtl/core/cse_dp.sv
// Result datapath: two bit-serial square roots, norm product, restoring divide.
// Depends on cse_pkg; driven by cse_ctrl commands.
module cse_dp (
	input  logic                        clk,
	input  cse_pkg::cse_cmd_t           cmd,
	input  cse_pkg::cse_fin_t           fin,
	output logic                        skip,
	output logic signed [cse_pkg::CSE_COS_W-1:0] cosine,
	output logic [cse_pkg::CSE_DOT_W-1:0] dot_sum,
	output cse_pkg::cse_status_t        status
);
	import cse_pkg::*;

	typedef struct packed {
		logic [CSE_ROOT_W-1:0] x;
		logic [CSE_ROOT_W-1:0] r;
	} root_t;

	function automatic root_t root_step(input logic [CSE_ROOT_W-1:0] x,
		input logic [CSE_ROOT_W-1:0] r, input logic [CSE_ROOT_W-1:0] b);
		root_t                 o;
		logic [CSE_ROOT_W-1:0] t;
		t = r + b;
		if (x >= t) begin
			o.x = x - t;
			o.r = (r >> 1) + b;
		end else begin
			o.x = x;
			o.r = r >> 1;
		end
		return o;
	endfunction

	logic [CSE_DOT_W-1:0]  dot_q;
	logic                  neg_q;
	cse_status_t           status_q;
	logic [CSE_ROOT_W-1:0] xa_q, xb_q, ra_q, rb_q, bit_q;
	logic [CSE_ROOT_W-1:0] den_q;
	logic [CSE_ROOT_W:0]   rem_q;
	logic                  sat_q;
	logic [CSE_FRAC_BITS-1:0] frac_q;

	root_t                 step_a, step_b;
	logic [CSE_NORM_W-1:0] na, nb;
	logic [CSE_ROOT_W-1:0] prod;
	logic [CSE_DOT_W-1:0]  mag;
	logic [CSE_ROOT_W-1:0] num;
	logic [CSE_ROOT_W:0]   rem_sh;
	logic [CSE_FRAC_BITS:0] rnd;
	logic [CSE_COS_W-1:0]  cos_mag;

	assign step_a = root_step(xa_q, ra_q, bit_q);
	assign step_b = root_step(xb_q, rb_q, bit_q);

	assign na   = ra_q[CSE_NORM_W-1:0];
	assign nb   = rb_q[CSE_NORM_W-1:0];
	assign prod = na * nb;

	assign mag    = neg_q ? (~dot_q + CSE_DOT_W'(1)) : dot_q;
	assign num    = {mag, CSE_NUM_SHIFT'(0)};
	assign rem_sh = {rem_q[CSE_ROOT_W-1:0], 1'b0};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dot_q <= fin.dot;
			neg_q <= fin.dot[CSE_DOT_W-1];
			if (fin.ovf) begin
				status_q <= ST_TOO_LONG;
			end else if (fin.sqa == '0 || fin.sqb == '0) begin
				status_q <= ST_ZERO_NORM;
			end else begin
				status_q <= ST_OK;
			end
			xa_q  <= {1'b0, fin.sqa, CSE_NUM_SHIFT'(0)};
			xb_q  <= {1'b0, fin.sqb, CSE_NUM_SHIFT'(0)};
			ra_q  <= '0;
			rb_q  <= '0;
			bit_q <= {2'b01, (CSE_ROOT_W-2)'(0)};
		end
		if (cmd.root) begin
			xa_q  <= step_a.x;
			ra_q  <= step_a.r;
			xb_q  <= step_b.x;
			rb_q  <= step_b.r;
			bit_q <= bit_q >> 2;
		end
		if (cmd.mult) begin
			den_q <= prod;
		end
		if (cmd.cmp) begin
			// integer part nonzero means the ratio is at least one
			sat_q  <= (num >= den_q);
			rem_q  <= {1'b0, num};
			frac_q <= '0;
		end
		if (cmd.div) begin
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q  <= rem_sh - {1'b0, den_q};
				frac_q <= {frac_q[CSE_FRAC_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				frac_q <= {frac_q[CSE_FRAC_BITS-2:0], 1'b0};
			end
		end
	end

	// round half up from 16 to 15 fraction bits, then saturate
	assign rnd = ({1'b0, frac_q} + (CSE_FRAC_BITS+1)'(1)) >> 1;
	assign cos_mag = (sat_q || rnd > {1'b0, CSE_COS_MAX}) ? CSE_COS_MAX
		: rnd[CSE_COS_W-1:0];

	always_comb begin
		if (status_q != ST_OK) begin
			cosine = '0;
		end else if (neg_q) begin
			cosine = -$signed(cos_mag);
		end else begin
			cosine = $signed(cos_mag);
		end
	end

	assign skip    = (status_q != ST_OK);
	assign dot_sum = dot_q;
	assign status  = status_q;

endmodule

### rtl/core/cse_ctrl.sv
// Controller that sequences the result datapath once per finished vector pair.
// Depends on cse_pkg.
module cse_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fin_valid,
	input  logic              skip,
	input  logic              out_free,
	output logic              idle,
	output cse_pkg::cse_cmd_t cmd
);
	import cse_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_ROOT,
		S_MULT,
		S_CMP,
		S_DIV,
		S_FIN
	} state_t;

	state_t                state_q;
	logic [CSE_CNT_W-1:0]  cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (fin_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					cnt_q   <= CSE_CNT_W'(CSE_ROOT_STEPS - 1);
					state_q <= skip ? S_FIN : S_ROOT;
				end
				S_ROOT: begin
					cnt_q <= cnt_q - CSE_CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= S_MULT;
					end
				end
				S_MULT: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					cnt_q   <= CSE_CNT_W'(CSE_DIV_STEPS - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - CSE_CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.load = (state_q == S_IDLE) && fin_valid;
		cmd.root = (state_q == S_ROOT);
		cmd.mult = (state_q == S_MULT);
		cmd.cmp  = (state_q == S_CMP);
		cmd.div  = (state_q == S_DIV);
		cmd.emit = (state_q == S_FIN) && out_free;
	end

	// a final pair in flight also counts as busy
	assign idle = (state_q == S_IDLE) && !fin_valid;

	a_fin_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fin_valid |-> state_q == S_IDLE)
		else $error("final pair reached a busy engine");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("result emitted into an occupied output register");

	a_root_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && !skip) |=> (state_q == S_ROOT &&
			cnt_q == CSE_CNT_W'(CSE_ROOT_STEPS - 1)))
		else $error("root sequence started with wrong step count");

	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q == '0) |=> state_q == S_FIN)
		else $error("divide did not finish after its last step");

endmodule

### rtl/core/cosine_similarity_engine.sv
// Cosine similarity engine: element pairs stream in at one per cycle while
// ready is high; each vector pair yields one transaction with the Q1.15 cosine,
// the dot product and a status code. A final pair is taken only while the result
// engine is free; its result comes from the 32-step bit-serial square roots and
// the 16-step restoring divide, both skipped when a norm is zero or the vector
// was too long. Pairs of the next vector keep streaming in while a result is
// computed or waits to be taken.
// Depends on cse_pkg, cse_in_if, cse_out_if, cse_accum, cse_ctrl, cse_dp.
module cosine_similarity_engine #(
	parameter int MAX_LEN   = cse_pkg::CSE_MAX_LEN,
	parameter int ELEM_BITS = cse_pkg::CSE_ELEM_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	cse_in_if.sink    elems,
	cse_out_if.source result
);
	import cse_pkg::*;

	logic        accept;
	logic        idle;
	logic        skip;
	logic        out_free;
	cse_fin_t    fin;
	cse_cmd_t    cmd;
	cse_status_t dp_status;

	logic signed [CSE_COS_W-1:0] dp_cosine;
	logic [CSE_DOT_W-1:0]        dp_dot;

	logic                        out_valid_q;
	logic signed [CSE_COS_W-1:0] cosine_q;
	logic [CSE_DOT_W-1:0]        dot_q;
	logic [1:0]                  status_q;

	assign elems.ready = !elems.last_element || idle;
	assign accept      = elems.valid && elems.ready;

	cse_accum #(
		.MAX_LEN   (MAX_LEN),
		.ELEM_BITS (ELEM_BITS)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.elem_a       (elems.elem_a),
		.elem_b       (elems.elem_b),
		.last_element (elems.last_element),
		.fin          (fin)
	);

	cse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fin_valid (fin.valid),
		.skip      (skip),
		.out_free  (out_free),
		.idle      (idle),
		.cmd       (cmd)
	);

	cse_dp u_dp (
		.clk     (clk),
		.cmd     (cmd),
		.fin     (fin),
		.skip    (skip),
		.cosine  (dp_cosine),
		.dot_sum (dp_dot),
		.status  (dp_status)
	);

	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			cosine_q <= dp_cosine;
			dot_q    <= dp_dot;
			status_q <= dp_status;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.cosine  = cosine_q;
	assign result.dot_sum = $signed(dot_q);
	assign result.status  = status_q;

endmodule
